// ===== design/i2cm_pkg.sv =====
// Package: types, constants and phase codes for the I2C master controller.
`timescale 1ns / 1ps
`default_nettype none
package i2cm_pkg;
    localparam int COUNT_BITS_DEF = 16;
    localparam int TIMER_BITS_DEF = 16;
    localparam int CFG_INDEX_BITS = 8;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_HALF    = 8'd0,
        CFG_QUARTER = 8'd1
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_BEGIN = 2'd1,
        MODE_BYTE  = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [4:0] {
        PH_IDLE, PH_START0, PH_START1, PH_TXSET, PH_TXHIGH, PH_TXLOW,
        PH_ACKHIGH, PH_ACKSAMPLE, PH_AFTER, PH_WAITBYTE, PH_RESTART,
        PH_RXSTART, PH_RXHIGH, PH_RXSAMPLE, PH_AOHIGH, PH_AOLOW,
        PH_STOP0, PH_STOP1
    } phase_t;

    typedef enum logic [1:0] {
        KIND_ADDR  = 2'd0,
        KIND_REG   = 2'd1,
        KIND_DATA  = 2'd2,
        KIND_RADDR = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic        sda_in;
        logic [6:0]  target_address;
        logic        is_read;
        logic        use_register;
        logic [7:0]  register_index;
        logic [15:0] byte_count;
        logic [7:0]  write_byte;
    } in_item_t;

    typedef struct packed {
        logic       scl_low;
        logic       sda_low;
        logic       need_byte;
        logic       read_valid;
        logic [7:0] read_data;
        logic       read_last;
        logic       busy_res;
        logic       done_res;
        logic       status;
    } out_item_t;

    localparam int QUEUE_DEPTH = 2;
endpackage
`default_nettype wire

// ===== design/i2cm_queue.sv =====
// Two-entry item queue between front and back.
`timescale 1ns / 1ps
`default_nettype none
module i2cm_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);
    logic [WIDTH-1:0] mem_reg [2];
    logic             wp_reg, rp_reg;
    logic [1:0]       cnt_reg;

    assign full    = cnt_reg == 2'd2;
    assign empty   = cnt_reg == 2'd0;
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en && !full)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_en && !full)
            begin
                wp_reg <= ~wp_reg;
            end
            if (rd_en && !empty)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'((wr_en && !full) ? 1 : 0) - 2'((rd_en && !empty) ? 1 : 0);
        end
    end
endmodule
`default_nettype wire

// ===== design/i2cm_engine.sv =====
// Bit-level sequencer: carries out one item per cycle while go is high and builds its result.
`timescale 1ns / 1ps
`default_nettype none
module i2cm_engine #(
    parameter int COUNT_BITS = i2cm_pkg::COUNT_BITS_DEF,
    parameter int TIMER_BITS = i2cm_pkg::TIMER_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                go,
    input  wire i2cm_pkg::in_item_t  item,
    input  wire logic [15:0]         half_ticks,
    input  wire logic [15:0]         quarter_ticks,
    output i2cm_pkg::out_item_t      res
);
    i2cm_pkg::phase_t        phase_reg, phase_next;
    logic [TIMER_BITS-1:0]   timer_reg, timer_next;
    logic [3:0]              bitc_reg, bitc_next;
    logic [7:0]              shift_reg, shift_next;
    logic [COUNT_BITS-1:0]   left_reg, left_next;
    logic [7:0]              held_reg, held_next;
    logic                    hvalid_reg, hvalid_next;
    logic [6:0]              addr_reg, addr_next;
    logic [7:0]              regi_reg, regi_next;
    logic [1:0]              flags_reg, flags_next;
    logic                    scl_reg, scl_next, sda_reg, sda_next;
    i2cm_pkg::kind_t         kind_reg, kind_next;
    logic                    stat_reg, stat_next;
    logic                    rv, rl, dn, ds;
    logic [7:0]              rd;
    logic [TIMER_BITS-1:0]   th, tq;
    logic [COUNT_BITS-1:0]   cnt_in;
    logic                    want;

    function automatic logic [TIMER_BITS-1:0] fit_t(input logic [15:0] v);
        logic [31:0] w;
        w = {16'd0, v};
        return w[TIMER_BITS-1:0];
    endfunction

    function automatic logic [COUNT_BITS-1:0] fit_c(input logic [15:0] v);
        logic [31:0] w;
        w = {16'd0, v};
        return w[COUNT_BITS-1:0];
    endfunction

    assign th     = fit_t(half_ticks);
    assign tq     = fit_t(quarter_ticks);
    assign cnt_in = fit_c(item.byte_count);

    always_comb
    begin
        logic run, cont;
        logic [COUNT_BITS-1:0] dec;
        phase_next = phase_reg; timer_next = timer_reg; bitc_next = bitc_reg;
        shift_next = shift_reg; left_next = left_reg; held_next = held_reg;
        hvalid_next = hvalid_reg; addr_next = addr_reg; regi_next = regi_reg;
        flags_next = flags_reg; scl_next = scl_reg; sda_next = sda_reg;
        kind_next = kind_reg; stat_next = stat_reg;
        rv = 1'b0; rd = 8'd0; rl = 1'b0; dn = 1'b0; ds = 1'b0;
        run = 1'b0; cont = 1'b0; dec = '0;
        if (go)
        begin
            case (item.mode)
                i2cm_pkg::MODE_BEGIN:
                begin
                    if (phase_reg == i2cm_pkg::PH_IDLE)
                    begin
                        addr_next  = item.target_address;
                        flags_next = {item.use_register, item.is_read};
                        regi_next  = item.register_index;
                        left_next  = (item.is_read && cnt_in == '0) ? COUNT_BITS'(1) : cnt_in;
                        hvalid_next = 1'b0; stat_next = 1'b0;
                        kind_next = i2cm_pkg::KIND_ADDR; bitc_next = 4'd0;
                        shift_next = 8'd0; timer_next = '0;
                        phase_next = i2cm_pkg::PH_START0;
                    end
                end
                i2cm_pkg::MODE_BYTE:
                begin
                    if (want)
                    begin
                        held_next = item.write_byte; hvalid_next = 1'b1;
                    end
                end
                i2cm_pkg::MODE_TICK:
                begin
                    if (timer_reg != '0)
                    begin
                        timer_next = timer_reg - 1'b1;
                    end
                    else
                    begin
                        run = phase_reg != i2cm_pkg::PH_IDLE;
                    end
                end
                default: ;
            endcase
        end
        // At most three chained actions (AFTER -> data branch -> TXSET,
        // AFTER -> RXSTART -> RXHIGH, AFTER -> STOP0).
        for (int k = 0; k < 3; k++)
        begin
            if (run)
            begin
                cont = 1'b0;
                unique case (phase_next)
                    i2cm_pkg::PH_START0:
                    begin
                        sda_next = 1'b1; timer_next = tq; phase_next = i2cm_pkg::PH_START1;
                    end
                    i2cm_pkg::PH_START1:
                    begin
                        scl_next = 1'b1; timer_next = th;
                        shift_next = {addr_next, (kind_next == i2cm_pkg::KIND_RADDR)
                                      || (flags_next == 2'b01)};
                        bitc_next = 4'd0; phase_next = i2cm_pkg::PH_TXSET;
                    end
                    i2cm_pkg::PH_TXSET:
                    begin
                        sda_next = !shift_next[7]; shift_next = {shift_next[6:0], 1'b0};
                        timer_next = th; phase_next = i2cm_pkg::PH_TXHIGH;
                    end
                    i2cm_pkg::PH_TXHIGH:
                    begin
                        scl_next = 1'b0; timer_next = th; phase_next = i2cm_pkg::PH_TXLOW;
                    end
                    i2cm_pkg::PH_TXLOW:
                    begin
                        scl_next = 1'b1; bitc_next = bitc_next + 4'd1;
                        if (bitc_next < 4'd8)
                        begin
                            sda_next = !shift_next[7]; shift_next = {shift_next[6:0], 1'b0};
                            phase_next = i2cm_pkg::PH_TXHIGH;
                        end
                        else
                        begin
                            sda_next = 1'b0; phase_next = i2cm_pkg::PH_ACKHIGH;
                        end
                        timer_next = th;
                    end
                    i2cm_pkg::PH_ACKHIGH:
                    begin
                        scl_next = 1'b0; timer_next = th; phase_next = i2cm_pkg::PH_ACKSAMPLE;
                    end
                    i2cm_pkg::PH_ACKSAMPLE:
                    begin
                        if (item.sda_in) stat_next = 1'b1;
                        scl_next = 1'b1; timer_next = th; phase_next = i2cm_pkg::PH_AFTER;
                    end
                    i2cm_pkg::PH_AFTER, i2cm_pkg::PH_WAITBYTE:
                    begin
                        cont = 1'b1;
                        if (phase_next == i2cm_pkg::PH_AFTER && stat_next)
                        begin
                            phase_next = i2cm_pkg::PH_STOP0;
                        end
                        else if (phase_next == i2cm_pkg::PH_AFTER
                                 && kind_next == i2cm_pkg::KIND_ADDR && flags_next[1])
                        begin
                            shift_next = regi_next; kind_next = i2cm_pkg::KIND_REG;
                            bitc_next = 4'd0; phase_next = i2cm_pkg::PH_TXSET;
                        end
                        else if (phase_next == i2cm_pkg::PH_AFTER
                                 && ((kind_next == i2cm_pkg::KIND_ADDR && flags_next[0])
                                     || kind_next == i2cm_pkg::KIND_RADDR))
                        begin
                            phase_next = i2cm_pkg::PH_RXSTART;
                        end
                        else if (phase_next == i2cm_pkg::PH_AFTER
                                 && kind_next == i2cm_pkg::KIND_REG && flags_next[0])
                        begin
                            phase_next = i2cm_pkg::PH_RESTART;
                        end
                        else if (left_next == '0)
                        begin
                            phase_next = i2cm_pkg::PH_STOP0;
                        end
                        else if (hvalid_next)
                        begin
                            shift_next = held_next; hvalid_next = 1'b0;
                            left_next = left_next - 1'b1; kind_next = i2cm_pkg::KIND_DATA;
                            bitc_next = 4'd0; phase_next = i2cm_pkg::PH_TXSET;
                        end
                        else
                        begin
                            phase_next = i2cm_pkg::PH_WAITBYTE; cont = 1'b0;
                        end
                    end
                    i2cm_pkg::PH_RESTART:
                    begin
                        scl_next = 1'b0; timer_next = tq; kind_next = i2cm_pkg::KIND_RADDR;
                        phase_next = i2cm_pkg::PH_START0;
                    end
                    i2cm_pkg::PH_RXSTART:
                    begin
                        shift_next = 8'd0; bitc_next = 4'd0;
                        phase_next = i2cm_pkg::PH_RXHIGH; cont = 1'b1;
                    end
                    i2cm_pkg::PH_RXHIGH:
                    begin
                        scl_next = 1'b0; timer_next = th; phase_next = i2cm_pkg::PH_RXSAMPLE;
                    end
                    i2cm_pkg::PH_RXSAMPLE:
                    begin
                        shift_next = {shift_next[6:0], item.sda_in};
                        bitc_next = bitc_next + 4'd1; scl_next = 1'b1;
                        if (bitc_next < 4'd8)
                        begin
                            phase_next = i2cm_pkg::PH_RXHIGH;
                        end
                        else
                        begin
                            rv = 1'b1; rd = shift_next;
                            rl = left_next <= COUNT_BITS'(1);
                            dec = left_next - 1'b1; left_next = dec;
                            sda_next = dec != '0; phase_next = i2cm_pkg::PH_AOHIGH;
                        end
                        timer_next = th;
                    end
                    i2cm_pkg::PH_AOHIGH:
                    begin
                        scl_next = 1'b0; timer_next = th; phase_next = i2cm_pkg::PH_AOLOW;
                    end
                    i2cm_pkg::PH_AOLOW:
                    begin
                        scl_next = 1'b1; sda_next = 1'b0; timer_next = th;
                        phase_next = (left_next != '0) ? i2cm_pkg::PH_RXSTART
                                                       : i2cm_pkg::PH_STOP0;
                    end
                    i2cm_pkg::PH_STOP0:
                    begin
                        sda_next = 1'b1; scl_next = 1'b0; timer_next = tq;
                        phase_next = i2cm_pkg::PH_STOP1;
                    end
                    i2cm_pkg::PH_STOP1:
                    begin
                        sda_next = 1'b0; phase_next = i2cm_pkg::PH_IDLE;
                        dn = 1'b1; ds = stat_next;
                    end
                    default:
                    begin
                        phase_next = i2cm_pkg::PH_IDLE; scl_next = 1'b0; sda_next = 1'b0;
                    end
                endcase
                run = cont;
            end
        end
    end

    always_comb
    begin
        want = phase_reg != i2cm_pkg::PH_IDLE && !flags_reg[0]
            && phase_reg != i2cm_pkg::PH_STOP0 && phase_reg != i2cm_pkg::PH_STOP1
            && left_reg != '0 && !hvalid_reg && !stat_reg;
    end

    always_comb
    begin
        res.scl_low    = scl_next;
        res.sda_low    = sda_next;
        res.need_byte  = phase_next != i2cm_pkg::PH_IDLE && !flags_next[0]
            && phase_next != i2cm_pkg::PH_STOP0 && phase_next != i2cm_pkg::PH_STOP1
            && left_next != '0 && !hvalid_next && !stat_next;
        res.read_valid = rv;
        res.read_data  = rd;
        res.read_last  = rl;
        res.busy_res   = phase_next != i2cm_pkg::PH_IDLE;
        res.done_res   = dn;
        res.status     = ds;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= i2cm_pkg::PH_IDLE; timer_reg <= '0; bitc_reg <= 4'd0;
            shift_reg <= 8'd0; left_reg <= '0; held_reg <= 8'd0; hvalid_reg <= 1'b0;
            addr_reg <= 7'd0; regi_reg <= 8'd0; flags_reg <= 2'd0;
            scl_reg <= 1'b0; sda_reg <= 1'b0; kind_reg <= i2cm_pkg::KIND_ADDR;
            stat_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next; timer_reg <= timer_next; bitc_reg <= bitc_next;
            shift_reg <= shift_next; left_reg <= left_next; held_reg <= held_next;
            hvalid_reg <= hvalid_next; addr_reg <= addr_next; regi_reg <= regi_next;
            flags_reg <= flags_next; scl_reg <= scl_next; sda_reg <= sda_next;
            kind_reg <= kind_next; stat_reg <= stat_next;
        end
    end
endmodule
`default_nettype wire

// ===== design/i2c_master_controller_unit.sv =====
// Top level of the I2C master controller.
// Usage:
//   Input items enter through push/full; each carries a mode (tick, begin,
//   supply byte, none) and the fields that mode uses. Results leave through
//   empty/pop, one result item per input item, in order.
//   Configuration: cfg_valid/cfg_ready with cfg_index 0 (half period ticks)
//   or 1 (quarter period ticks); ready is always high. Write only when idle.
//   An input item is queued in a two-entry input queue and executed by the
//   sequencer once it is at the head and the output queue has room; its
//   result goes into the two-entry output queue feeding the result ports.
//   Throughput: one item per cycle while the output queue has room.
//   When pop is held low the output queue fills, the sequencer stops and
//   the input queue then raises full; nothing is lost.
//   Reset clears both queues, the sequencer (idle, both lines released)
//   and restores the tick registers to 250 and 125.
`timescale 1ns / 1ps
`default_nettype none
module i2c_master_controller_unit #(
    parameter int COUNT_BITS = i2cm_pkg::COUNT_BITS_DEF,
    parameter int TIMER_BITS = i2cm_pkg::TIMER_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire i2cm_pkg::in_item_t  in_item,
    output logic                     empty,
    input  wire logic                pop,
    output i2cm_pkg::out_item_t      out_item,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [i2cm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [15:0]         cfg_data
);
    logic [15:0]          half_reg, quarter_reg;
    i2cm_pkg::in_item_t   q_item;
    i2cm_pkg::out_item_t  res;
    logic                 q_empty, o_full, go;

    assign cfg_ready = 1'b1;
    assign go = !q_empty && !o_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg    <= 16'd250;
            quarter_reg <= 16'd125;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == i2cm_pkg::CFG_HALF) half_reg <= cfg_data;
            if (cfg_index == i2cm_pkg::CFG_QUARTER) quarter_reg <= cfg_data;
        end
    end

    i2cm_queue #(.WIDTH($bits(i2cm_pkg::in_item_t))) u_inq (
        .clk, .rst_n, .wr_en(push), .wr_data(in_item), .full,
        .rd_en(go), .rd_data(q_item), .empty(q_empty)
    );

    i2cm_engine #(.COUNT_BITS(COUNT_BITS), .TIMER_BITS(TIMER_BITS)) u_eng (
        .clk, .rst_n, .go, .item(q_item), .half_ticks(half_reg),
        .quarter_ticks(quarter_reg), .res
    );

    i2cm_queue #(.WIDTH($bits(i2cm_pkg::out_item_t))) u_outq (
        .clk, .rst_n, .wr_en(go), .wr_data(res), .full(o_full),
        .rd_en(pop), .rd_data(out_item), .empty
    );
endmodule
`default_nettype wire

// ===== design/i2cm_checker.sv =====
// Port-level checker for the I2C master controller, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module i2cm_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                push,
    input wire logic                full,
    input wire logic                empty,
    input wire logic                pop,
    input wire i2cm_pkg::out_item_t out_item
);
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(out_item))
        else $error("result changed while stalled");
    a_read_fields: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !out_item.read_valid |-> out_item.read_data == 8'd0 && !out_item.read_last)
        else $error("read fields without valid");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && out_item.done_res |-> !out_item.busy_res)
        else $error("done while busy");
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !out_item.done_res |-> !out_item.status)
        else $error("status without done");
    a_push_fill: assert property (@(posedge clk) disable iff (!rst_n)
        empty && !push |=> empty || !full)
        else $error("queue sides inconsistent");
endmodule

bind i2c_master_controller_unit i2cm_checker u_chk (
    .clk, .rst_n, .push, .full, .empty, .pop, .out_item
);
`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench: I2C master controller, checked item by item against a built-in sequencer model.
`timescale 1ns / 1ps
module testbench;
    import i2cm_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        bit          is_cfg;
        cfg_index_t  idx;
        logic [15:0] val;
        in_item_t    it;
        bit          chk;
        out_item_t   e;
        int          run;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    in_item_t    in_item;
    logic        empty;
    logic        pop;
    out_item_t   out_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [15:0] cfg_data;

    out_item_t   expected_q[$];
    row_t        rows[$];
    int          errors;
    int          n_items;
    int          cycles;
    bit          gaps_on;

    // sequencer model state
    phase_t      ph;
    logic [15:0] dly;
    logic [3:0]  bitc;
    logic [7:0]  shv;
    logic [15:0] left;
    logic [7:0]  hold;
    bit          hold_v;
    logic [6:0]  addr_s;
    logic [7:0]  reg_s;
    logic [1:0]  flags;
    bit          scl_d;
    bit          sda_d;
    kind_t       kind;
    bit          nacked;
    logic [15:0] half_t;
    logic [15:0] quar_t;
    out_item_t   res;

    i2c_master_controller_unit uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .empty(empty), .pop(pop), .out_item(out_item), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic bit wants_byte();
        return ph != PH_IDLE && !flags[0] && ph != PH_STOP0 && ph != PH_STOP1
            && left != 0 && !hold_v && !nacked;
    endfunction

    function automatic bit next_data();
        if (left == 0)
        begin
            ph = PH_STOP0;
            return 1;
        end
        if (hold_v)
        begin
            shv = hold;
            hold_v = 0;
            left = left - 1;
            kind = KIND_DATA;
            bitc = 0;
            ph = PH_TXSET;
            return 1;
        end
        ph = PH_WAITBYTE;
        return 0;
    endfunction

    function automatic bit seq_action(logic sda);
        case (ph)
            PH_START0:
            begin
                sda_d = 1; dly = quar_t; ph = PH_START1;
            end
            PH_START1:
            begin
                scl_d = 1; dly = half_t;
                shv = {addr_s, 1'b0};
                if (kind == KIND_RADDR || flags == 2'b01) shv[0] = 1'b1;
                bitc = 0; ph = PH_TXSET;
            end
            PH_TXSET:
            begin
                sda_d = ~shv[7]; shv = shv << 1; dly = half_t; ph = PH_TXHIGH;
            end
            PH_TXHIGH:
            begin
                scl_d = 0; dly = half_t; ph = PH_TXLOW;
            end
            PH_TXLOW:
            begin
                scl_d = 1;
                bitc = bitc + 1;
                if (bitc < 8)
                begin
                    sda_d = ~shv[7]; shv = shv << 1; ph = PH_TXHIGH;
                end
                else
                begin
                    sda_d = 0; ph = PH_ACKHIGH;
                end
                dly = half_t;
            end
            PH_ACKHIGH:
            begin
                scl_d = 0; dly = half_t; ph = PH_ACKSAMPLE;
            end
            PH_ACKSAMPLE:
            begin
                if (sda) nacked = 1;
                scl_d = 1; dly = half_t; ph = PH_AFTER;
            end
            PH_AFTER:
            begin
                if (nacked)
                begin
                    ph = PH_STOP0;
                    return 1;
                end
                if (kind == KIND_ADDR)
                begin
                    if (flags[1])
                    begin
                        shv = reg_s; kind = KIND_REG; bitc = 0; ph = PH_TXSET;
                        return 1;
                    end
                    if (flags[0])
                    begin
                        ph = PH_RXSTART;
                        return 1;
                    end
                    return next_data();
                end
                if (kind == KIND_REG)
                begin
                    if (flags[0])
                    begin
                        ph = PH_RESTART;
                        return 1;
                    end
                    return next_data();
                end
                if (kind == KIND_RADDR)
                begin
                    ph = PH_RXSTART;
                    return 1;
                end
                return next_data();
            end
            PH_WAITBYTE: return next_data();
            PH_RESTART:
            begin
                scl_d = 0; dly = quar_t; kind = KIND_RADDR; ph = PH_START0;
            end
            PH_RXSTART:
            begin
                shv = 0; bitc = 0; ph = PH_RXHIGH;
                return 1;
            end
            PH_RXHIGH:
            begin
                scl_d = 0; dly = half_t; ph = PH_RXSAMPLE;
            end
            PH_RXSAMPLE:
            begin
                shv = {shv[6:0], sda};
                bitc = bitc + 1;
                scl_d = 1;
                if (bitc < 8)
                    ph = PH_RXHIGH;
                else
                begin
                    res.read_valid = 1;
                    res.read_data = shv;
                    res.read_last = (left <= 1);
                    left = left - 1;
                    sda_d = (left != 0);
                    ph = PH_AOHIGH;
                end
                dly = half_t;
            end
            PH_AOHIGH:
            begin
                scl_d = 0; dly = half_t; ph = PH_AOLOW;
            end
            PH_AOLOW:
            begin
                scl_d = 1; sda_d = 0; dly = half_t;
                ph = (left != 0) ? PH_RXSTART : PH_STOP0;
            end
            PH_STOP0:
            begin
                sda_d = 1; scl_d = 0; dly = quar_t; ph = PH_STOP1;
            end
            PH_STOP1:
            begin
                sda_d = 0; ph = PH_IDLE;
                res.done_res = 1; res.status = nacked;
            end
            default:
            begin
                ph = PH_IDLE; scl_d = 0; sda_d = 0;
            end
        endcase
        return 0;
    endfunction

    function automatic out_item_t controller_step(in_item_t it);
        int g;
        res = '0;
        case (mode_t'(it.mode))
            MODE_BEGIN:
                if (ph == PH_IDLE)
                begin
                    addr_s = it.target_address;
                    flags = {it.use_register, it.is_read};
                    reg_s = it.register_index;
                    left = it.byte_count;
                    if (flags[0] && left == 0) left = 1;
                    hold_v = 0; nacked = 0; kind = KIND_ADDR;
                    bitc = 0; shv = 0; dly = 0; ph = PH_START0;
                end
            MODE_BYTE:
                if (wants_byte())
                begin
                    hold = it.write_byte;
                    hold_v = 1;
                end
            MODE_TICK:
                if (dly != 0)
                    dly = dly - 1;
                else if (ph != PH_IDLE)
                begin
                    g = 0;
                    while (seq_action(it.sda_in) && g < 8) g++;
                end
            default: ;
        endcase
        res.scl_low = scl_d;
        res.sda_low = sda_d;
        res.need_byte = wants_byte();
        res.busy_res = (ph != PH_IDLE);
        return res;
    endfunction

    function automatic in_item_t rnd_item(mode_t m);
        logic [63:0] v;
        in_item_t it;
        v = {$urandom(), $urandom()};
        it = v[$bits(in_item_t)-1:0];
        it.mode = m;
        return it;
    endfunction

    function automatic out_item_t lines(bit scl, bit sda, bit need, bit busy);
        out_item_t o;
        o = '0;
        o.scl_low = scl; o.sda_low = sda; o.need_byte = need; o.busy_res = busy;
        return o;
    endfunction

    task automatic report(string what, int got, int want);
        errors++;
        $display("mismatch %s: got %0h, expected %0h", what, got, want);
    endtask

    task automatic put_item(in_item_t it, bit typed = 0, out_item_t e = '0);
        out_item_t p;
        if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        push <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (full) @(posedge clk);
        p = controller_step(it);
        expected_q.push_back(typed ? e : p);
        n_items++;
    endtask

    task automatic write_cfg(cfg_index_t idx, logic [15:0] val);
        push <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_HALF) half_t = val;
        else quar_t = val;
    endtask

    // drive the open transfer to its end; target NACKs at the given ACK (0: never)
    task automatic run_transfer(int nack_at, bit noise);
        int acks;
        int r;
        logic sda;
        in_item_t it;
        acks = 0;
        while (ph != PH_IDLE)
        begin
            r = $urandom_range(0, 99);
            if (noise && r < 3)
                put_item(rnd_item(r == 0 ? MODE_NONE : r == 1 ? MODE_BEGIN : MODE_BYTE));
            else if (wants_byte() && r < 60)
                put_item(rnd_item(MODE_BYTE));
            else
            begin
                sda = $urandom_range(0, 1);
                if (ph == PH_ACKSAMPLE && dly == 0)
                begin
                    acks++;
                    sda = (acks == nack_at);
                end
                it = rnd_item(MODE_TICK);
                it.sda_in = sda;
                put_item(it);
            end
        end
    endtask

    task automatic add_row(in_item_t it, int run, bit chk = 0, out_item_t e = '0);
        row_t r;
        r.is_cfg = 0; r.idx = CFG_HALF; r.val = 0;
        r.it = it; r.chk = chk; r.e = e; r.run = run;
        rows.push_back(r);
    endtask

    task automatic add_cfg(cfg_index_t idx, logic [15:0] val);
        row_t r;
        r.is_cfg = 1; r.idx = idx; r.val = val;
        r.it = '0; r.chk = 0; r.e = '0; r.run = -1;
        rows.push_back(r);
    endtask

    function automatic in_item_t begin_item(logic [6:0] a, bit rd, bit ureg, logic [7:0] ri,
                                            logic [15:0] cnt);
        in_item_t it;
        it = rnd_item(MODE_BEGIN);
        it.target_address = a; it.is_read = rd; it.use_register = ureg;
        it.register_index = ri; it.byte_count = cnt;
        return it;
    endfunction

    always @(posedge clk)
    begin
        out_item_t w;
        if (rst_n && pop && !empty)
        begin
            if (expected_q.size() == 0)
                report("unexpected item", out_item, 0);
            else
            begin
                w = expected_q.pop_front();
                if (out_item.scl_low != w.scl_low) report("scl_low", out_item.scl_low, w.scl_low);
                if (out_item.sda_low != w.sda_low) report("sda_low", out_item.sda_low, w.sda_low);
                if (out_item.need_byte != w.need_byte)
                    report("need_byte", out_item.need_byte, w.need_byte);
                if (out_item.read_valid != w.read_valid)
                    report("read_valid", out_item.read_valid, w.read_valid);
                if (out_item.read_data != w.read_data)
                    report("read_data", out_item.read_data, w.read_data);
                if (out_item.read_last != w.read_last)
                    report("read_last", out_item.read_last, w.read_last);
                if (out_item.busy_res != w.busy_res)
                    report("busy_res", out_item.busy_res, w.busy_res);
                if (out_item.done_res != w.done_res)
                    report("done_res", out_item.done_res, w.done_res);
                if (out_item.status != w.status) report("status", out_item.status, w.status);
            end
        end
    end

    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (gaps_on && $urandom_range(0, 5) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
        end
    end

    initial
    begin
        in_item_t it;
        row_t r;
        logic [15:0] hv;
        logic [15:0] qv;
        rst_n = 1'b0;
        push = 1'b0;
        in_item = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0; n_items = 0; cycles = 0; gaps_on = 1;
        ph = PH_IDLE; dly = 0; bitc = 0; shv = 0; left = 0; hold = 0; hold_v = 0;
        addr_s = 0; reg_s = 0; flags = 0; scl_d = 0; sda_d = 0; kind = KIND_ADDR;
        nacked = 0; half_t = 250; quar_t = 125;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        add_row(rnd_item(MODE_TICK), -1, 1, lines(0, 0, 0, 0));
        add_row(rnd_item(MODE_NONE), -1, 1, lines(0, 0, 0, 0));
        add_row(rnd_item(MODE_BYTE), -1, 1, lines(0, 0, 0, 0));
        add_cfg(CFG_HALF, 16'd1);
        add_cfg(CFG_QUARTER, 16'd1);
        add_row(begin_item(7'h7F, 0, 1, 8'hFF, 16'hFFFF), -1, 1, lines(0, 0, 1, 1));
        add_row(rnd_item(MODE_BYTE), -1);
        add_row(begin_item(7'h00, 1, 0, 8'h00, 16'h0001), -1);
        add_row(rnd_item(MODE_TICK), 1);
        add_row(begin_item(7'h00, 0, 0, 8'h00, 16'h0000), 0);
        add_row(begin_item(7'h55, 0, 1, 8'h00, 16'h0002), 0);
        add_row(begin_item(7'h2A, 1, 0, 8'h00, 16'h0000), 0);
        add_row(begin_item(7'h7F, 1, 1, 8'h80, 16'h0003), 0);
        add_row(begin_item(7'h11, 0, 0, 8'h00, 16'h0003), 3);
        add_row(begin_item(7'h33, 1, 0, 8'h00, 16'h0002), 1);
        add_row(begin_item(7'h44, 1, 1, 8'hA5, 16'h0002), 2);
        foreach (rows[i])
        begin
            r = rows[i];
            if (r.is_cfg)
                write_cfg(r.idx, r.val);
            else
            begin
                put_item(r.it, r.chk, r.e);
                if (r.run >= 0) run_transfer(r.run, 0);
            end
        end

        // random part
        while (n_items < 1300)
        begin
            if (n_items > 1100) gaps_on = 0;
            if (gaps_on && $urandom_range(0, 3) == 0)
            begin
                hv = ($urandom_range(0, 4) == 0) ? 16'd1 : 16'($urandom_range(1, 4));
                qv = ($urandom_range(0, 4) == 0) ? 16'd1 : 16'($urandom_range(1, 4));
                write_cfg(CFG_HALF, hv);
                write_cfg(CFG_QUARTER, qv);
            end
            it = rnd_item(MODE_BEGIN);
            it.byte_count = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(4, 10))
                                                         : 16'($urandom_range(0, 3));
            put_item(it);
            run_transfer(($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0, 1);
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3))
                    put_item(rnd_item($urandom_range(0, 1) ? MODE_NONE : MODE_BYTE));
        end

        // largest tick settings
        write_cfg(CFG_HALF, 16'hFFFF);
        write_cfg(CFG_QUARTER, 16'hFFFF);
        put_item(begin_item(7'h5A, 0, 1, 8'h3C, 16'h0002));
        repeat (40) put_item(rnd_item(MODE_TICK));

        push <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
